/* src/cfc_pkg.sv */
// Package for the CRC-16 length-framed checker.
// Beat types, frame constants and the byte-wise CRC-16 (0x1021) update.
// No dependencies.
`timescale 1ns / 1ps

package cfc_pkg;

  localparam logic [8:0]  PosSat  = 9'd263;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [8:0]  AckPos  = 9'd3;
  localparam logic [8:0]  LenPos  = 9'd4;
  localparam logic [8:0]  MinLen  = 9'd5;
  localparam logic [8:0]  HiOfs   = 9'd5;
  localparam logic [8:0]  LoOfs   = 9'd6;
  localparam logic [8:0]  FullOfs = 9'd7;
  localparam logic [7:0]  AckCode = 8'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_idle;
  } cfc_in_t;

  typedef struct packed {
    logic        frame_ok;
    logic        ack_requested;
    logic [7:0]  payload_length;
    logic [15:0] computed_crc;
    logic [8:0]  bytes_seen;
  } cfc_out_t;

  // MSB-first CRC-16 over one byte, no reflection, no final xor
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/cfc_in_stage.sv */
// Input register stage of the CRC-16 frame checker.
// Holds one accepted beat until the frame tracker takes it; uses cfc_pkg.
`timescale 1ns / 1ps

module cfc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cfc_pkg::cfc_in_t in_data_i,
  input  logic            advance_i,
  output logic            beat_valid_o,
  output cfc_pkg::cfc_in_t beat_o
);

  logic             valid_q, valid_d;
  cfc_pkg::cfc_in_t data_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = data_q;

endmodule

/* src/cfc_frame.sv */
// Frame tracker of the CRC-16 frame checker: position, CRC, captured bytes.
// Forms the verdict for an idle beat; uses cfc_pkg.
`timescale 1ns / 1ps

module cfc_frame #(
  parameter int MAX_FRAME_BYTES = 140
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  cfc_pkg::cfc_in_t beat_i,
  output cfc_pkg::cfc_out_t verdict_o
);

  logic [15:0] crc_q, crc_d;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic        ack_q, ack_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  lo_q, lo_d;

  logic [8:0] len_ext;
  logic       complete, fits, match, ok;

  assign len_ext = {1'b0, len_q};

  always_comb begin
    crc_d = crc_q;
    pos_d = pos_q;
    len_d = len_q;
    ack_d = ack_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (take_i) begin
      if (beat_i.line_idle) begin
        // verdict goes out this beat; start a fresh frame
        crc_d = '0;
        pos_d = '0;
        len_d = '0;
        ack_d = 1'b0;
        hi_d  = '0;
        lo_d  = '0;
      end else if (pos_q < cfc_pkg::PosSat) begin
        if (pos_q == cfc_pkg::AckPos) begin
          ack_d = (beat_i.rx_byte == cfc_pkg::AckCode);
        end
        if (pos_q == cfc_pkg::LenPos) begin
          len_d = beat_i.rx_byte;
        end
        // length byte itself falls in the header branch, so len_q is safe here
        if (pos_q <= cfc_pkg::LenPos || pos_q < len_ext + cfc_pkg::HiOfs) begin
          crc_d = cfc_pkg::crc16_byte(crc_q, beat_i.rx_byte);
        end else if (pos_q == len_ext + cfc_pkg::HiOfs) begin
          hi_d = beat_i.rx_byte;
        end else if (pos_q == len_ext + cfc_pkg::LoOfs) begin
          lo_d = beat_i.rx_byte;
        end
        pos_d = pos_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      pos_q <= '0;
      len_q <= '0;
      ack_q <= 1'b0;
      hi_q  <= '0;
      lo_q  <= '0;
    end else begin
      crc_q <= crc_d;
      pos_q <= pos_d;
      len_q <= len_d;
      ack_q <= ack_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

  assign complete = (pos_q >= cfc_pkg::MinLen) && (pos_q >= len_ext + cfc_pkg::FullOfs);
  assign fits     = (pos_q <= 9'(MAX_FRAME_BYTES));
  assign match    = (hi_q == crc_q[15:8]) && (lo_q == crc_q[7:0]);
  assign ok       = complete && fits && match;

  always_comb begin
    verdict_o.frame_ok       = ok;
    verdict_o.ack_requested  = ok && ack_q;
    verdict_o.payload_length = len_q;
    verdict_o.computed_crc   = crc_q;
    verdict_o.bytes_seen     = pos_q;
  end

endmodule

/* src/cfc_out_stage.sv */
// Result register of the CRC-16 frame checker.
// Holds one verdict until the downstream side takes it; uses cfc_pkg.
`timescale 1ns / 1ps

module cfc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cfc_pkg::cfc_out_t verdict_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfc_pkg::cfc_out_t out_data_o
);

  logic              valid_q, valid_d;
  cfc_pkg::cfc_out_t data_q;

  // room for a new verdict when empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= verdict_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* src/crc16_length_framed_checker.sv */
// Top level of the CRC-16 length-framed checker.
// Instantiates cfc_in_stage, cfc_frame and cfc_out_stage; uses cfc_pkg.
`timescale 1ns / 1ps

// Takes one received byte per beat and accepts a beat every cycle. A beat with
// line_idle set closes the frame: its verdict is registered as that beat leaves
// the input register and stays until taken, while the next frame's
// bytes keep flowing in. Throughput is one beat per cycle, set by the single
// byte-wide CRC-16 update between the input register and the frame state; only
// an idle beat meeting a verdict that has not been taken yet waits.

module crc16_length_framed_checker #(
  parameter int MAX_FRAME_BYTES = 140
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cfc_pkg::cfc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfc_pkg::cfc_out_t out_data_o
);

  logic              beat_valid;
  cfc_pkg::cfc_in_t  beat;
  cfc_pkg::cfc_out_t verdict;
  logic              out_free;
  logic              advance;

  // a byte beat never waits; an idle beat needs room in the result register
  assign advance = beat_valid && (!beat.line_idle || out_free);

  cfc_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .advance_i    (advance),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  cfc_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk_i,
    .rst_ni,
    .take_i    (advance),
    .beat_i    (beat),
    .verdict_o (verdict)
  );

  cfc_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i      (advance && beat.line_idle),
    .verdict_i   (verdict),
    .free_o      (out_free),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

/* src/cfc_checker.sv */
// Port-level checks for the CRC-16 length-framed checker.
// Bound to crc16_length_framed_checker; uses cfc_pkg.
`timescale 1ns / 1ps

module cfc_checker #(
  parameter int MAX_FRAME_BYTES = 140
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cfc_pkg::cfc_out_t out_data_o
);

  // stalled verdict holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("verdict dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ack_requested |-> out_data_o.frame_ok)
    else $error("ack requested on a bad frame");

  // a good frame holds header, payload and both check bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_ok |->
      out_data_o.bytes_seen >= {1'b0, out_data_o.payload_length} + cfc_pkg::FullOfs)
    else $error("good verdict on a short frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_ok |-> out_data_o.bytes_seen <= 9'(MAX_FRAME_BYTES))
    else $error("good verdict on an overflowing frame");

endmodule

bind crc16_length_framed_checker cfc_checker #(
  .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
) u_cfc_checker (.*);

/* tb/sv/tb_crc16_length_framed_checker.sv */
// Self-checking testbench for crc16_length_framed_checker.
// Sends framed byte streams and predicts each verdict with a local CRC-16 frame tracker.
// Depends on cfc_pkg (beat types) and the checker RTL.
`timescale 1ns / 1ps

module tb_crc16_length_framed_checker;

  localparam int          FRAME_CAP   = 140;
  localparam int          POS_LIMIT   = 263;
  localparam logic [15:0] CCITT_POLY  = 16'h1021;
  localparam logic [7:0]  ACK_WANTED  = 8'd1;
  localparam int          ITEM_GOAL   = 1850;

  // CRC corruption choices for generated frames
  typedef enum int {CORRUPT_NONE, CORRUPT_HIGH, CORRUPT_LOW} crc_damage_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  cfc_pkg::cfc_in_t  in_data   = '0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  cfc_pkg::cfc_out_t out_data;

  crc16_length_framed_checker #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // frame tracker state
  logic [15:0] trk_crc;
  logic [8:0]  trk_pos;
  logic [7:0]  trk_len;
  logic        trk_ack;
  logic [7:0]  trk_hi;
  logic [7:0]  trk_lo;

  cfc_pkg::cfc_out_t verdict_q[$];
  cfc_pkg::cfc_out_t taken_verdict;
  logic [7:0] frame_bytes[$];
  int         beats_sent  = 0;
  int         mismatches  = 0;
  int         burst_left  = 0;
  int         ready_run   = 0;
  bit         tx_gaps_on  = 1'b0;
  bit         rx_stalls_on = 1'b0;

  function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_tracker();
    trk_crc = '0;
    trk_pos = '0;
    trk_len = '0;
    trk_ack = 1'b0;
    trk_hi  = '0;
    trk_lo  = '0;
  endfunction

  // Advance the tracker by one accepted beat; an idle beat yields a verdict.
  function automatic void track_frame_beat(input cfc_pkg::cfc_in_t beat);
    int                pos;
    int                len;
    bit                complete;
    bit                fits;
    bit                match;
    cfc_pkg::cfc_out_t v;
    pos = int'(trk_pos);
    len = int'(trk_len);
    if (!beat.line_idle) begin
      if (pos < POS_LIMIT) begin
        if (pos == 3) trk_ack = (beat.rx_byte == ACK_WANTED);
        if (pos == 4) begin
          trk_len = beat.rx_byte;
          len     = int'(beat.rx_byte);
        end
        if (pos <= 4 || pos < len + 5) begin
          trk_crc = ccitt_update(trk_crc, beat.rx_byte);
        end else if (pos == len + 5) begin
          trk_hi = beat.rx_byte;
        end else if (pos == len + 6) begin
          trk_lo = beat.rx_byte;
        end
        trk_pos = trk_pos + 9'd1;
      end
    end else begin
      complete = (pos >= 5) && (pos >= len + 7);
      fits     = (pos <= FRAME_CAP);
      match    = (trk_hi == trk_crc[15:8]) && (trk_lo == trk_crc[7:0]);
      v.frame_ok       = complete && fits && match;
      v.ack_requested  = v.frame_ok && trk_ack;
      v.payload_length = trk_len;
      v.computed_crc   = trk_crc;
      v.bytes_seen     = trk_pos;
      verdict_q.push_back(v);
      clear_tracker();
    end
  endfunction

  // Present one beat, holding it until accepted; bursts with random gaps.
  task automatic send_beat(input cfc_pkg::cfc_in_t beat);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (tx_gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready);
    beats_sent++;
    track_frame_beat(beat);
  endtask

  // Send the bytes held in frame_bytes, then close with an idle beat.
  task automatic send_frame();
    cfc_pkg::cfc_in_t beat;
    foreach (frame_bytes[i]) begin
      beat.rx_byte   = frame_bytes[i];
      beat.line_idle = 1'b0;
      send_beat(beat);
    end
    beat.rx_byte   = 8'($urandom);
    beat.line_idle = 1'b1;
    send_beat(beat);
  endtask

  // Build a frame: three random header bytes, ack flag, length, payload, CRC, trailing bytes.
  task automatic build_frame(input logic [7:0] ack, input int len, input int trailing,
                             input crc_damage_e damage);
    logic [15:0] crc;
    crc = '0;
    frame_bytes.delete();
    repeat (3) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(ack);
    frame_bytes.push_back(8'(len));
    repeat (len) frame_bytes.push_back(8'($urandom));
    foreach (frame_bytes[i]) crc = ccitt_update(crc, frame_bytes[i]);
    if (damage == CORRUPT_HIGH) crc[8 + $urandom_range(0, 7)] ^= 1'b1;
    if (damage == CORRUPT_LOW)  crc[$urandom_range(0, 7)] ^= 1'b1;
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    repeat (trailing) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic test_empty_and_short();
    frame_bytes.delete();
    send_frame();
    send_frame();
    // header cut before the length byte
    repeat (3) frame_bytes.push_back(8'($urandom));
    send_frame();
    // length byte present, payload and check bytes missing
    build_frame(ACK_WANTED, 4, 0, CORRUPT_NONE);
    repeat (6) void'(frame_bytes.pop_back());
    send_frame();
  endtask

  task automatic test_good_frames();
    build_frame(ACK_WANTED, 0, 0, CORRUPT_NONE);
    send_frame();
    build_frame(8'hFF, 1, 0, CORRUPT_NONE);
    send_frame();
    build_frame(8'h00, 2, 0, CORRUPT_NONE);
    send_frame();
  endtask

  task automatic test_bad_crc();
    build_frame(ACK_WANTED, 1, 0, CORRUPT_HIGH);
    send_frame();
    build_frame(ACK_WANTED, 1, 0, CORRUPT_LOW);
    send_frame();
  endtask

  task automatic test_trailing_bytes();
    build_frame(ACK_WANTED, 2, 3, CORRUPT_NONE);
    send_frame();
  endtask

  task automatic test_buffer_limits();
    build_frame(ACK_WANTED, FRAME_CAP - 7, 0, CORRUPT_NONE);
    send_frame();
    build_frame(ACK_WANTED, FRAME_CAP - 7, 1, CORRUPT_NONE);
    send_frame();
    build_frame(8'h00, FRAME_CAP - 6, 0, CORRUPT_NONE);
    send_frame();
    build_frame(ACK_WANTED, 255, 0, CORRUPT_NONE);
    send_frame();
  endtask

  task automatic test_long_stream();
    frame_bytes.delete();
    repeat (300) frame_bytes.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic test_random_frames();
    int pick;
    int len;
    int room;
    logic [7:0] ack;
    while (beats_sent < ITEM_GOAL) begin
      // switch between idling and full-rate stretches now and then
      if ($urandom_range(0, 15) == 0) begin
        tx_gaps_on   = ($urandom_range(0, 1) == 1);
        rx_stalls_on = ($urandom_range(0, 1) == 1);
      end
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_CAP - 7)
                                         : $urandom_range(0, 12);
      room = FRAME_CAP - 7 - len;
      ack  = $urandom_range(0, 1) ? ACK_WANTED : 8'($urandom);
      if (pick < 60) begin
        build_frame(ack, len,
                    (room > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, room) : 0,
                    CORRUPT_NONE);
      end else if (pick < 75) begin
        build_frame(ack, len, 0, $urandom_range(0, 1) ? CORRUPT_HIGH : CORRUPT_LOW);
      end else if (pick < 85) begin
        build_frame(ack, len, 0, CORRUPT_NONE);
        repeat ($urandom_range(1, frame_bytes.size())) void'(frame_bytes.pop_back());
      end else if (pick < 92) begin
        if ($urandom_range(0, 1)) begin
          build_frame(ack, len, room + 1 + $urandom_range(0, 5), CORRUPT_NONE);
        end else begin
          build_frame(ack, $urandom_range(FRAME_CAP - 6, 255), 0, CORRUPT_NONE);
        end
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(0, 20)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
    end
  endtask

  // Receiver: alternate ready and stall runs of random length.
  always @(posedge clk_i) begin
    if (!rx_stalls_on) begin
      out_ready <= 1'b1;
    end else if (ready_run == 0) begin
      ready_run = $urandom_range(1, 12);
      out_ready <= ~out_ready;
    end else begin
      ready_run--;
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected verdict, expected none, actual %0h", $time, out_data);
      end else begin
        taken_verdict = verdict_q.pop_front();
        check_field("frame_ok", taken_verdict.frame_ok, out_data.frame_ok);
        check_field("ack_requested", taken_verdict.ack_requested, out_data.ack_requested);
        check_field("payload_length", taken_verdict.payload_length, out_data.payload_length);
        check_field("computed_crc", taken_verdict.computed_crc, out_data.computed_crc);
        check_field("bytes_seen", taken_verdict.bytes_seen, out_data.bytes_seen);
      end
    end
  end

  initial begin
    clear_tracker();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_short();
    test_good_frames();
    test_bad_crc();
    test_trailing_bytes();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    test_buffer_limits();
    test_long_stream();
    test_random_frames();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* crc16_length_framed_checker.f */
src/cfc_pkg.sv
src/cfc_in_stage.sv
src/cfc_frame.sv
src/cfc_out_stage.sv
src/crc16_length_framed_checker.sv
src/cfc_checker.sv
tb/sv/tb_crc16_length_framed_checker.sv
